// File: design/dq_pkg.sv
// Shared types and codes for the double-ended queue.
package dq_pkg;

    typedef logic signed [31:0] word_t;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SIZE       = 3'd4,
        CMD_EMPTY      = 3'd5,
        CMD_FRONT      = 3'd6,
        CMD_BACK       = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_in;   // push at the front: every word moves one cell back
        logic shift_out;  // pop at the front: every word moves one cell forward
        logic push_back;  // write the cell at the current count
    } cell_ctrl_t;

    localparam word_t EMPTY_WORD = -32'sd1;

endpackage

// File: design/dq_cell.sv
// One storage cell of the queue chain; exchanges its word with both neighbors.
module dq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 11
) (
    input  logic               clk,
    input  dq_pkg::word_t      left_word,
    input  dq_pkg::word_t      right_word,
    input  dq_pkg::word_t      push_value,
    input  logic [CW-1:0]      count,
    input  dq_pkg::cell_ctrl_t ctrl,
    output dq_pkg::word_t      word,
    output dq_pkg::word_t      tap
);
    import dq_pkg::*;

    word_t word_reg;
    word_t word_next;
    logic  is_tail_slot;
    logic  is_last;

    assign is_tail_slot = (count == CW'(IDX));
    assign is_last      = (count == CW'(IDX + 1));

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.shift_in)
        begin
            word_next = left_word;
        end
        else if (ctrl.shift_out)
        begin
            word_next = right_word;
        end
        else if (ctrl.push_back && is_tail_slot)
        begin
            word_next = push_value;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    // Offer the word to the back-read tree only when this cell holds the back.
    assign tap  = is_last ? word_reg : '0;

endmodule

// File: design/dq_tree.sv
// Registered OR tree that gathers the single nonzero tap of the chain.
module dq_tree #(
    parameter int DEPTH = 1024
) (
    input  logic                          clk,
    input  dq_pkg::word_t [DEPTH-1:0]     taps,
    output dq_pkg::word_t                 root
);
    import dq_pkg::*;

    localparam int LVL = $clog2(DEPTH);
    localparam int P   = 1 << LVL;

    word_t leaf [P];
    word_t node_reg [1:P-1];

    genvar j;
    generate
        for (j = 0; j < P; j++)
        begin : g_leaf
            if (j < DEPTH)
            begin : g_used
                assign leaf[j] = taps[j];
            end
            else
            begin : g_pad
                assign leaf[j] = '0;
            end
        end
    endgenerate

    genvar i;
    generate
        for (i = 1; i < P; i++)
        begin : g_node
            if (2 * i >= P)
            begin : g_bottom
                always_ff @(posedge clk)
                begin
                    node_reg[i] <= leaf[2*i-P] | leaf[2*i+1-P];
                end
            end
            else
            begin : g_inner
                always_ff @(posedge clk)
                begin
                    node_reg[i] <= node_reg[2*i] | node_reg[2*i+1];
                end
            end
        end
    endgenerate

    assign root = node_reg[1];

endmodule

// File: design/double_ended_queue.sv
// Double-ended queue of signed 32-bit words built as a shifting chain of cells.
//
// The queue is a row of DEPTH cells with the front always in cell 0: a push or
// pop at the front shifts the whole row by one cell, a push at the back writes
// the cell at the current count. Each command that is taken has its result, if
// any, in the output register on the next cycle. The back word is read through
// a registered OR tree of clog2(DEPTH) levels, so a pop back or back command
// issued while the tree still reflects an older queue is held off until the
// tree has settled; all other commands, and back reads of an unchanged queue,
// run at one per clock while no result waits on a stalled output. A push gives
// no result unless the queue is full, in which case it is dropped and answered
// with status full. Pops and peeks on an empty queue answer data -1 with status
// empty.
module double_ended_queue #(
    parameter int DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  dq_pkg::cmd_t      command,
    input  dq_pkg::word_t     push_value,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output dq_pkg::word_t     data,
    output dq_pkg::status_t   status
);
    import dq_pkg::*;

    localparam int LVL = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int SW  = $clog2(LVL + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [SW-1:0] settle_reg;
    logic [SW-1:0] settle_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    word_t         data_reg;
    word_t         data_next;
    status_t       status_reg;
    status_t       status_next;

    word_t              words [DEPTH];
    word_t [DEPTH-1:0]  taps;
    word_t              back_word;
    cell_ctrl_t         ctrl;

    logic  cmd_fire;
    logic  is_back_read;
    logic  q_empty;
    logic  q_full;
    logic  has_rsp;
    logic  changed;
    word_t rsp_data;
    status_t rsp_status;

    assign q_empty      = (count_reg == '0);
    assign q_full       = (count_reg == CW'(DEPTH));
    assign is_back_read = (command == CMD_POP_BACK) || (command == CMD_BACK);

    // Hold while a result waits, or a back read while the tree shows an old queue.
    assign cmd_stall = (rsp_valid_reg && rsp_stall) || (is_back_read && (settle_reg != '0));
    assign cmd_fire  = cmd_valid && !cmd_stall;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            word_t left_w;
            word_t right_w;

            if (k == 0)
            begin : g_first
                assign left_w = push_value;
            end
            else
            begin : g_mid_l
                assign left_w = words[k-1];
            end

            if (k == DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = words[k+1];
            end

            dq_cell #(
                .IDX (k),
                .CW  (CW)
            ) u_cell (
                .clk        (clk),
                .left_word  (left_w),
                .right_word (right_w),
                .push_value (push_value),
                .count      (count_reg),
                .ctrl       (ctrl),
                .word       (words[k]),
                .tap        (taps[k])
            );
        end
    endgenerate

    dq_tree #(
        .DEPTH (DEPTH)
    ) u_tree (
        .clk  (clk),
        .taps (taps),
        .root (back_word)
    );

    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        has_rsp    = 1'b0;
        changed    = 1'b0;
        rsp_data   = '0;
        rsp_status = ST_OK;
        unique case (command) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (q_full)
                begin
                    has_rsp    = 1'b1;
                    rsp_status = ST_FULL;
                end
                else
                begin
                    ctrl.shift_in  = (command == CMD_PUSH_FRONT);
                    ctrl.push_back = (command == CMD_PUSH_BACK);
                    count_next     = count_reg + 1'b1;
                    changed        = 1'b1;
                end
            end
            CMD_SIZE:
            begin
                has_rsp  = 1'b1;
                rsp_data = 32'(count_reg);
            end
            CMD_EMPTY:
            begin
                has_rsp  = 1'b1;
                rsp_data = 32'(q_empty);
            end
            CMD_POP_FRONT, CMD_FRONT:
            begin
                has_rsp = 1'b1;
                if (q_empty)
                begin
                    rsp_data   = EMPTY_WORD;
                    rsp_status = ST_EMPTY;
                end
                else
                begin
                    rsp_data = words[0];
                    if (command == CMD_POP_FRONT)
                    begin
                        ctrl.shift_out = 1'b1;
                        count_next     = count_reg - 1'b1;
                        changed        = 1'b1;
                    end
                end
            end
            CMD_POP_BACK, CMD_BACK:
            begin
                has_rsp = 1'b1;
                if (q_empty)
                begin
                    rsp_data   = EMPTY_WORD;
                    rsp_status = ST_EMPTY;
                end
                else
                begin
                    rsp_data = back_word;
                    if (command == CMD_POP_BACK)
                    begin
                        count_next = count_reg - 1'b1;
                        changed    = 1'b1;
                    end
                end
            end
            default:
            begin
                has_rsp = 1'b0;
            end
        endcase

        // Drop everything when no request is taken this cycle.
        if (!cmd_fire)
        begin
            ctrl       = '0;
            count_next = count_reg;
            has_rsp    = 1'b0;
            changed    = 1'b0;
        end
    end

    always_comb
    begin
        settle_next = settle_reg;
        if (changed)
        begin
            settle_next = SW'(LVL);
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - 1'b1;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        data_next      = data_reg;
        status_next    = status_reg;
        if (has_rsp)
        begin
            rsp_valid_next = 1'b1;
            data_next      = rsp_data;
            status_next    = rsp_status;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            settle_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            settle_reg    <= settle_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_back_settled: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && is_back_read |-> settle_reg == '0)
        else $error("back read taken before tree settled");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && (command == CMD_PUSH_FRONT || command == CMD_PUSH_BACK) && !q_full
        |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("accepted push did not grow the queue");

    a_full_reported: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && (command == CMD_PUSH_FRONT || command == CMD_PUSH_BACK) && q_full
        |=> rsp_valid_reg && status_reg == ST_FULL && $stable(count_reg))
        else $error("dropped push not reported");

    a_change_arms_settle: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> settle_reg == SW'(LVL))
        else $error("queue changed without rearming settle counter");

endmodule
